/* rtl/cdts_pkg.sv */
// Shared types and constants for the clock display and time-set controller.
package cdts_pkg;

    localparam int unsigned CFG_AW    = 4;
    localparam int unsigned CFG_DW    = 32;
    localparam int unsigned PERIOD_W  = 16;
    localparam int unsigned IN_TDW    = 24;
    localparam int unsigned OUT_TDW   = 24;

    localparam logic [PERIOD_W-1:0] TICK_MAX        = 16'hFFFF;
    localparam logic [PERIOD_W-1:0] TIME_TICKS_RST  = 16'd20;
    localparam logic [PERIOD_W-1:0] DATE_TICKS_RST  = 16'd6;
    localparam logic [PERIOD_W-1:0] TEMP_TICKS_RST  = 16'd6;

    localparam logic [3:0] LIM_MIN_LO  = 4'd9;
    localparam logic [3:0] LIM_MIN_HI  = 4'd5;
    localparam logic [3:0] LIM_HOUR_LO = 4'd9;
    localparam logic [3:0] LIM_HOUR_HI = 4'd2;

    typedef enum logic [1:0] {
        REG_TIME_TICKS = 2'd0,
        REG_DATE_TICKS = 2'd1,
        REG_TEMP_TICKS = 2'd2,
        REG_NONE       = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        VIEW_POST    = 3'd0,
        VIEW_TIME    = 3'd1,
        VIEW_DATE    = 3'd2,
        VIEW_TEMP    = 3'd3,
        VIEW_MIN_LO  = 3'd4,
        VIEW_MIN_HI  = 3'd5,
        VIEW_HOUR_LO = 3'd6,
        VIEW_HOUR_HI = 3'd7
    } t_view;

    typedef struct packed {
        logic [7:0] rtc_hour;
        logic [7:0] rtc_minute;
        logic       half_tick;
        logic       down_press;
        logic       up_press;
        logic       menu_long_press;
        logic       menu_press;
    } t_in_item;

    typedef struct packed {
        logic       sync_enabled;
        logic       post_done;
        logic       beep_strobe;
        logic       save_strobe;
        logic [7:0] hour_value;
        logic [7:0] minute_value;
        logic [2:0] view_code;
    } t_out_item;

    typedef struct packed {
        logic [PERIOD_W-1:0] time_ticks;
        logic [PERIOD_W-1:0] date_ticks;
        logic [PERIOD_W-1:0] temp_ticks;
    } t_cfg;

    typedef struct packed {
        logic valid;
    } t_stage_ctl;

endpackage

/* rtl/cdts_cfg.sv */
// APB register file holding the three view periods.
module cdts_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cdts_pkg::CFG_AW-1:0]    paddr,
    input  logic [cdts_pkg::CFG_DW-1:0]    pwdata,
    output logic [cdts_pkg::CFG_DW-1:0]    prdata,
    output logic                           pready,
    output cdts_pkg::t_cfg                 o_cfg
);

    cdts_pkg::t_cfg     r_cfg;
    cdts_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign w_idx  = cdts_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_ticks <= cdts_pkg::TIME_TICKS_RST;
            r_cfg.date_ticks <= cdts_pkg::DATE_TICKS_RST;
            r_cfg.temp_ticks <= cdts_pkg::TEMP_TICKS_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                cdts_pkg::REG_TIME_TICKS: r_cfg.time_ticks <= pwdata[15:0];
                cdts_pkg::REG_DATE_TICKS: r_cfg.date_ticks <= pwdata[15:0];
                cdts_pkg::REG_TEMP_TICKS: r_cfg.temp_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            cdts_pkg::REG_TIME_TICKS: prdata = {16'd0, r_cfg.time_ticks};
            cdts_pkg::REG_DATE_TICKS: prdata = {16'd0, r_cfg.date_ticks};
            cdts_pkg::REG_TEMP_TICKS: prdata = {16'd0, r_cfg.temp_ticks};
            default:                  prdata = '0;
        endcase
    end

endmodule

/* rtl/cdts_in_reg.sv */
// Input register stage for button poll items.
module cdts_in_reg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_tvalid,
    output logic                            o_tready,
    input  logic [cdts_pkg::IN_TDW-1:0]     i_tdata,
    input  logic                            i_advance,
    output cdts_pkg::t_stage_ctl            o_ctl,
    output cdts_pkg::t_in_item              o_item
);

    logic               r_valid;
    cdts_pkg::t_in_item r_item;
    logic               w_take;

    assign o_tready     = !r_valid || i_advance;
    assign w_take       = i_tvalid && o_tready;
    assign o_ctl.valid  = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= cdts_pkg::t_in_item'(i_tdata[20:0]);
        end
    end

endmodule

/* rtl/cdts_core.sv */
// View state machine, time-set digit editing and result register.
module cdts_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cdts_pkg::t_cfg                  i_cfg,
    input  cdts_pkg::t_stage_ctl            i_ctl,
    input  cdts_pkg::t_in_item              i_item,
    output logic                            o_advance,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [cdts_pkg::OUT_TDW-1:0]    o_tdata
);

    function automatic logic [7:0] edit_digit(input logic [7:0] b, input logic hi,
                                              input logic [3:0] lim, input logic up,
                                              input logic dn);
        logic [3:0] dig;
        dig = hi ? b[7:4] : b[3:0];
        if (up) dig = (dig == lim) ? 4'd0 : dig + 4'd1;
        if (dn) dig = (dig == 4'd0) ? lim : dig - 4'd1;
        return hi ? {dig, b[3:0]} : {b[7:4], dig};
    endfunction

    cdts_pkg::t_view         r_view, n_view;
    logic [15:0]             r_cnt, n_cnt;
    logic [7:0]              r_min, n_min;
    logic [7:0]              r_hour, n_hour;
    logic                    r_sync, n_sync;
    logic                    r_out_valid;
    cdts_pkg::t_out_item     r_out, n_out;

    cdts_pkg::t_view         w_v1, w_v2;
    logic [15:0]             w_cnt0, w_cnt1, w_cnt2;
    logic [7:0]              w_min0, w_hour0;
    logic                    w_save, w_post;

    assign o_advance = i_ctl.valid && (!r_out_valid || i_tready);
    assign o_tvalid  = r_out_valid;
    assign o_tdata   = {1'b0, r_out};

    always_comb begin
        w_cnt0  = r_cnt;
        w_min0  = r_min;
        w_hour0 = r_hour;
        if (i_item.half_tick) begin
            if (r_sync) begin
                w_min0  = i_item.rtc_minute;
                w_hour0 = i_item.rtc_hour;
            end
            if (r_cnt != cdts_pkg::TICK_MAX) w_cnt0 = r_cnt + 16'd1;
        end

        w_v1   = r_view;
        w_cnt1 = w_cnt0;
        w_save = 1'b0;
        n_sync = r_sync;
        if (i_item.menu_long_press) begin
            w_cnt1 = '0;
            w_save = r_view[2];
            n_sync = r_view[2];
            w_v1   = r_view[2] ? cdts_pkg::VIEW_TIME : cdts_pkg::VIEW_MIN_LO;
        end

        w_v2   = w_v1;
        w_cnt2 = w_cnt1;
        w_post = 1'b0;
        if (w_v1 == cdts_pkg::VIEW_TIME
            && (w_cnt1 >= i_cfg.time_ticks || i_item.menu_press)) begin
            w_v2 = cdts_pkg::VIEW_DATE;
            w_cnt2 = '0;
        end else if (w_v1 == cdts_pkg::VIEW_DATE
            && (w_cnt1 >= i_cfg.date_ticks || i_item.menu_press)) begin
            w_v2 = cdts_pkg::VIEW_TEMP;
            w_cnt2 = '0;
        end else if (w_v1 == cdts_pkg::VIEW_TEMP
            && (w_cnt1 >= i_cfg.temp_ticks || i_item.menu_press)) begin
            w_v2 = cdts_pkg::VIEW_TIME;
            w_cnt2 = '0;
        end else if (w_v1 == cdts_pkg::VIEW_POST) begin
            w_v2 = cdts_pkg::VIEW_TIME;
            w_cnt2 = '0;
            w_post = 1'b1;
        end
    end

    always_comb begin
        n_view = w_v2;
        n_cnt  = w_cnt2;
        n_min  = w_min0;
        n_hour = w_hour0;
        unique case (w_v2)
            cdts_pkg::VIEW_MIN_LO: begin
                n_min = edit_digit(w_min0, 1'b0, cdts_pkg::LIM_MIN_LO,
                                   i_item.up_press, i_item.down_press);
                if (i_item.menu_press) n_view = cdts_pkg::VIEW_MIN_HI;
            end
            cdts_pkg::VIEW_MIN_HI: begin
                n_min = edit_digit(w_min0, 1'b1, cdts_pkg::LIM_MIN_HI,
                                   i_item.up_press, i_item.down_press);
                if (i_item.menu_press) n_view = cdts_pkg::VIEW_HOUR_LO;
            end
            cdts_pkg::VIEW_HOUR_LO: begin
                n_hour = edit_digit(w_hour0, 1'b0, cdts_pkg::LIM_HOUR_LO,
                                    i_item.up_press, i_item.down_press);
                if (i_item.menu_press) n_view = cdts_pkg::VIEW_HOUR_HI;
            end
            cdts_pkg::VIEW_HOUR_HI: begin
                n_hour = edit_digit(w_hour0, 1'b1, cdts_pkg::LIM_HOUR_HI,
                                    i_item.up_press, i_item.down_press);
                if (i_item.menu_press) n_view = cdts_pkg::VIEW_MIN_LO;
            end
            default: ;
        endcase
        if (n_view != w_v2) n_cnt = '0;
    end

    always_comb begin
        n_out.view_code    = n_view;
        n_out.minute_value = n_min;
        n_out.hour_value   = n_hour;
        n_out.save_strobe  = w_save;
        n_out.beep_strobe  = i_item.menu_press || i_item.menu_long_press
                             || i_item.up_press || i_item.down_press;
        n_out.post_done    = w_post;
        n_out.sync_enabled = n_sync;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view      <= cdts_pkg::VIEW_POST;
            r_cnt       <= '0;
            r_min       <= '0;
            r_hour      <= '0;
            r_sync      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_view      <= n_view;
                r_cnt       <= n_cnt;
                r_min       <= n_min;
                r_hour      <= n_hour;
                r_sync      <= n_sync;
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_out <= n_out;
        end
    end

endmodule

/* rtl/clock_display_and_time_set_fsm.sv */
// Top level of the clock display and time-set controller.
//
//  channel  | dir | handshake                     | contents
//  ---------+-----+-------------------------------+-------------------------------
//  s_*      | in  | s_tvalid / s_tready           | one button poll item
//  m_*      | out | m_tvalid / m_tready           | one display/result item
//  apb      | in  | psel & penable & pwrite       | view periods at 0x0, 0x4, 0x8
//
// One item per cycle sustained while m_tready stays high; the result is registered
// behind two registers in turn (input register, then the state update and result
// register).
// Synchronous active-low reset clears the view to power-on, the tick count and
// time registers to zero, enables sync, and restores the default periods.
// A stalled result holds in the output register; the input register still
// takes one more item, and further input waits until the result is taken.
module clock_display_and_time_set_fsm (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [0] menu_press, [1] menu_long_press, [2] up_press, [3] down_press,
    // [4] half_tick, [12:5] rtc_minute, [20:13] rtc_hour, [23:21] zero
    input  logic [cdts_pkg::IN_TDW-1:0]    s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] view_code, [10:3] minute_value, [18:11] hour_value,
    // [19] save_strobe, [20] beep_strobe, [21] post_done, [22] sync_enabled,
    // [23] zero
    output logic [cdts_pkg::OUT_TDW-1:0]   m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cdts_pkg::CFG_AW-1:0]    paddr,
    input  logic [cdts_pkg::CFG_DW-1:0]    pwdata,
    output logic [cdts_pkg::CFG_DW-1:0]    prdata,
    output logic                           pready
);

    cdts_pkg::t_cfg       w_cfg;
    cdts_pkg::t_stage_ctl w_ctl;
    cdts_pkg::t_in_item   w_item;
    logic                 w_advance;

    cdts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cdts_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (s_tvalid),
        .o_tready  (s_tready),
        .i_tdata   (s_tdata),
        .i_advance (w_advance),
        .o_ctl     (w_ctl),
        .o_item    (w_item)
    );

    cdts_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_ctl     (w_ctl),
        .i_item    (w_item),
        .o_advance (w_advance),
        .o_tvalid  (m_tvalid),
        .i_tready  (m_tready),
        .o_tdata   (m_tdata)
    );

endmodule

/* bench/clock_display_result_checker.sv */
`timescale 1ns / 100ps
// Result checker: predicts each display item from the accepted polls and compares.
module clock_display_result_checker
    import cdts_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [IN_TDW-1:0]   i_s_tdata,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [OUT_TDW-1:0]  i_m_tdata,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [CFG_AW-1:0]   i_paddr,
    input  logic [CFG_DW-1:0]   i_pwdata,
    input  logic                i_pready,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int MAX_REPORTS = 10;

    t_view          view_q;
    logic [15:0]    tick_cnt;
    logic [7:0]     minute_q;
    logic [7:0]     hour_q;
    logic           sync_q;
    t_cfg           periods;
    t_out_item      pending_displays[$];
    int             fails;

    function automatic logic [3:0] step_digit(logic [3:0] d, logic [3:0] lim,
                                              logic up, logic dn);
        logic [3:0] r;
        r = d;
        if (up) r = (r == lim) ? 4'd0 : r + 4'd1;
        if (dn) r = (r == 4'd0) ? lim : r - 4'd1;
        return r;
    endfunction

    function automatic t_out_item next_display(t_in_item p);
        t_out_item r;
        logic      save;
        logic      post;
        save = 1'b0;
        post = 1'b0;
        if (p.half_tick) begin
            if (sync_q) begin
                minute_q = p.rtc_minute;
                hour_q   = p.rtc_hour;
            end
            if (tick_cnt != TICK_MAX) tick_cnt = tick_cnt + 16'd1;
        end
        if (p.menu_long_press) begin
            if (view_q >= VIEW_MIN_LO) begin
                view_q = VIEW_TIME;
                save   = 1'b1;
                sync_q = 1'b1;
            end else begin
                view_q = VIEW_MIN_LO;
                sync_q = 1'b0;
            end
            tick_cnt = '0;
        end
        case (view_q)
            VIEW_POST: begin
                view_q   = VIEW_TIME;
                tick_cnt = '0;
                post     = 1'b1;
            end
            VIEW_TIME: begin
                if (tick_cnt >= periods.time_ticks || p.menu_press) begin
                    view_q   = VIEW_DATE;
                    tick_cnt = '0;
                end
            end
            VIEW_DATE: begin
                if (tick_cnt >= periods.date_ticks || p.menu_press) begin
                    view_q   = VIEW_TEMP;
                    tick_cnt = '0;
                end
            end
            VIEW_TEMP: begin
                if (tick_cnt >= periods.temp_ticks || p.menu_press) begin
                    view_q   = VIEW_TIME;
                    tick_cnt = '0;
                end
            end
            default: ;
        endcase
        case (view_q)
            VIEW_MIN_LO: begin
                minute_q[3:0] = step_digit(minute_q[3:0], LIM_MIN_LO, p.up_press,
                                           p.down_press);
                if (p.menu_press) begin
                    view_q   = VIEW_MIN_HI;
                    tick_cnt = '0;
                end
            end
            VIEW_MIN_HI: begin
                minute_q[7:4] = step_digit(minute_q[7:4], LIM_MIN_HI, p.up_press,
                                           p.down_press);
                if (p.menu_press) begin
                    view_q   = VIEW_HOUR_LO;
                    tick_cnt = '0;
                end
            end
            VIEW_HOUR_LO: begin
                hour_q[3:0] = step_digit(hour_q[3:0], LIM_HOUR_LO, p.up_press,
                                         p.down_press);
                if (p.menu_press) begin
                    view_q   = VIEW_HOUR_HI;
                    tick_cnt = '0;
                end
            end
            VIEW_HOUR_HI: begin
                hour_q[7:4] = step_digit(hour_q[7:4], LIM_HOUR_HI, p.up_press,
                                         p.down_press);
                if (p.menu_press) begin
                    view_q   = VIEW_MIN_LO;
                    tick_cnt = '0;
                end
            end
            default: ;
        endcase
        r.view_code    = view_q;
        r.minute_value = minute_q;
        r.hour_value   = hour_q;
        r.save_strobe  = save;
        r.beep_strobe  = p.menu_press | p.menu_long_press | p.up_press | p.down_press;
        r.post_done    = post;
        r.sync_enabled = sync_q;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            view_q             = VIEW_POST;
            tick_cnt           = '0;
            minute_q           = '0;
            hour_q             = '0;
            sync_q             = 1'b1;
            periods.time_ticks = TIME_TICKS_RST;
            periods.date_ticks = DATE_TICKS_RST;
            periods.temp_ticks = TEMP_TICKS_RST;
            pending_displays.delete();
            fails = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_TIME_TICKS: periods.time_ticks = i_pwdata[15:0];
                    REG_DATE_TICKS: periods.date_ticks = i_pwdata[15:0];
                    REG_TEMP_TICKS: periods.temp_ticks = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                pending_displays.push_back(next_display(t_in_item'(i_s_tdata[20:0])));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_out_item'(i_m_tdata[22:0]);
                if (pending_displays.size() == 0) begin
                    fails = fails + 1;
                    if (fails <= MAX_REPORTS) begin
                        $display("%0t: result with nothing expected, data %h", $time,
                                 i_m_tdata);
                    end
                end else begin
                    want = pending_displays.pop_front();
                    if (got !== want) begin
                        fails = fails + 1;
                        if (fails <= MAX_REPORTS) begin
                            $display({"%0t: mismatch (expected/actual) view %0d/%0d ",
                                      "min %h/%h hour %h/%h save %b/%b beep %b/%b ",
                                      "post %b/%b sync %b/%b"}, $time,
                                     want.view_code, got.view_code,
                                     want.minute_value, got.minute_value,
                                     want.hour_value, got.hour_value,
                                     want.save_strobe, got.save_strobe,
                                     want.beep_strobe, got.beep_strobe,
                                     want.post_done, got.post_done,
                                     want.sync_enabled, got.sync_enabled);
                        end
                    end
                end
            end
        end
        o_pending    <= pending_displays.size();
        o_fail_count <= fails;
    end

endmodule

/* bench/clock_display_and_time_set_fsm_tb.sv */
`timescale 1ns / 100ps
// Testbench top: drives button polls and view periods, then gives the verdict.
module clock_display_and_time_set_fsm_tb;
    import cdts_pkg::*;

    localparam logic [4:0]  B_NONE      = 5'b00000;
    localparam logic [4:0]  B_MENU      = 5'b00001;
    localparam logic [4:0]  B_LONG      = 5'b00010;
    localparam logic [4:0]  B_UP        = 5'b00100;
    localparam logic [4:0]  B_DOWN      = 5'b01000;
    localparam logic [4:0]  B_TICK      = 5'b10000;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned SOAK_ITEMS  = 30;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_TDW-1:0]    s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_TDW-1:0]   m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [CFG_AW-1:0]    paddr;
    logic [CFG_DW-1:0]    pwdata;
    logic [CFG_DW-1:0]    prdata;
    logic                 pready;
    int                   fail_count;
    int                   pending;
    int unsigned          quiet_cycles;
    bit                   idle_en;
    bit                   hold_off_req;
    t_view                seen_view;

    clock_display_and_time_set_fsm dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    clock_display_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (m_tvalid && m_tready) seen_view <= t_view'(m_tdata[2:0]);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : sink
        m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    function automatic t_in_item random_poll();
        t_in_item    p;
        int unsigned hr;
        p                 = '0;
        p.half_tick       = 1'($urandom_range(0, 1));
        p.menu_press      = ($urandom_range(0, 6) == 0);
        p.menu_long_press = ($urandom_range(0, 19) == 0);
        p.up_press        = ($urandom_range(0, 3) == 0);
        p.down_press      = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0) begin
            p.rtc_minute = 8'($urandom);
            p.rtc_hour   = 8'($urandom);
        end else begin
            hr           = $urandom_range(0, 23);
            p.rtc_minute = {4'($urandom_range(0, 5)), 4'($urandom_range(0, 9))};
            p.rtc_hour   = {4'(hr / 10), 4'(hr % 10)};
        end
        return p;
    endfunction

    task automatic send_poll(input t_in_item p);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDW'(p);
        do begin
            @(posedge i_clk);
        end while (!s_tready);
    endtask

    task automatic poll(input logic [4:0] buttons, input logic [7:0] mn, input logic [7:0] hr);
        send_poll(t_in_item'({hr, mn, buttons}));
    endtask

    task automatic send_random(input int unsigned n);
        repeat (n) send_poll(random_poll());
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= CFG_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_periods(input logic [15:0] t, input logic [15:0] d,
                               input logic [15:0] tp);
        write_reg(REG_TIME_TICKS, t);
        write_reg(REG_DATE_TICKS, d);
        write_reg(REG_TEMP_TICKS, tp);
    endtask

    initial begin : stimulus
        bit first_long;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        i_rst_n  <= 1'b0;
        idle_en      = 1'b1;
        hold_off_req = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // leave power-on either through its own path or straight into setup
        first_long = 1'($urandom_range(0, 1));
        poll(first_long ? B_LONG : B_NONE, 8'h00, 8'h00);
        if (first_long) poll(B_LONG, 8'h00, 8'h00);
        poll(B_TICK, 8'hFF, 8'hFF);
        poll(B_LONG, 8'h00, 8'h00);
        poll(B_UP, 8'h00, 8'h00);
        poll(B_DOWN, 8'h00, 8'h00);
        poll(B_UP, 8'h00, 8'h00);
        poll(B_UP | B_DOWN, 8'h00, 8'h00);
        poll(B_TICK | B_MENU, 8'h00, 8'h00);
        poll(B_DOWN, 8'h00, 8'h00);
        poll(B_UP, 8'h00, 8'h00);
        poll(B_UP, 8'h00, 8'h00);
        poll(B_DOWN, 8'h00, 8'h00);
        poll(B_UP | B_MENU, 8'h00, 8'h00);
        poll(B_UP, 8'h00, 8'h00);
        poll(B_DOWN | B_MENU, 8'h00, 8'h00);
        poll(B_UP, 8'h00, 8'h00);
        poll(B_DOWN, 8'h00, 8'h00);
        poll(B_UP | B_MENU, 8'h00, 8'h00);
        poll(B_LONG | B_MENU, 8'h00, 8'h00);
        poll(B_TICK, 8'h00, 8'h00);
        poll(B_TICK | B_MENU, 8'h59, 8'h23);
        poll(B_MENU, 8'h00, 8'h00);
        poll(B_TICK | B_MENU | B_LONG | B_UP | B_DOWN, 8'h12, 8'h07);
        poll(B_LONG, 8'h00, 8'h00);
        send_random(200);
        drain();

        set_periods(16'd1, 16'd1, 16'd1);
        hold_off_req = 1'b1;
        send_random(250);
        drain();

        set_periods(16'd0, 16'($urandom_range(0, 3)), 16'hFFFF);
        send_random(250);
        drain();

        set_periods(16'($urandom_range(2, 40)), 16'($urandom_range(2, 40)),
                    16'($urandom_range(2, 40)));
        send_random(200);
        drain();

        // park in the time view with a fresh count, then tick against the longest period
        set_periods(16'hFFFF, 16'd1, 16'd1);
        if (seen_view < VIEW_MIN_LO) poll(B_LONG, 8'h00, 8'h00);
        poll(B_LONG, 8'h00, 8'h00);
        repeat (SOAK_ITEMS) begin
            poll(B_TICK, 8'($urandom), 8'($urandom));
        end
        drain();

        set_periods(16'($urandom_range(1, 30)), 16'($urandom_range(1, 30)),
                    16'($urandom_range(1, 30)));
        idle_en = 1'b0;
        send_random(150);
        drain();

        repeat (10) @(posedge i_clk);
        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/cdts_pkg.sv
rtl/cdts_cfg.sv
rtl/cdts_in_reg.sv
rtl/cdts_core.sv
rtl/clock_display_and_time_set_fsm.sv
bench/clock_display_result_checker.sv
bench/clock_display_and_time_set_fsm_tb.sv
